// ===== hdl/cdv_pkg.sv =====
// ----------------------------------------------------------------------------
// cdv_pkg
// shared types, constants and the mod-11 check digit function for the
// registry number check digit validator
// ----------------------------------------------------------------------------
package cdv_pkg;

    // field widths
    localparam int NUM_W       = 47;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int CHK_W       = 7;
    localparam int SUM_W       = 10;
    localparam int ALT_W       = 7;
    localparam int DIGIT_W     = 4;

    // binary to decimal conversion: 48 shifted bits, 15 decimal digits
    localparam int BIN_W      = 48;
    localparam int DIGITS     = 15;
    localparam int BCD_W      = DIGITS * DIGIT_W;
    localparam int STEP_BITS  = 8;
    localparam int DAB_STAGES = BIN_W / STEP_BITS;

    // digit positions, counted from the units digit
    localparam int LEAD_POS    = 13;  // most significant digit of the 14-digit form
    localparam int SUM_DIGITS  = 12;  // root and branch digits
    localparam int ROOT_POS    = 6;
    localparam int ROOT_DIGITS = 8;

    // check digit weights, most significant digit first
    localparam logic [3:0] W_FIRST  [SUM_DIGITS] = '{5, 4, 3, 2, 9, 8, 7, 6, 5, 4, 3, 2};
    localparam logic [3:0] W_SECOND [SUM_DIGITS] = '{6, 5, 4, 3, 2, 9, 8, 7, 6, 5, 4, 3};
    localparam logic [3:0] W_SECOND_LAST = 4'd2;  // weight of the first check digit

    // mod 11 by reciprocal: floor(s * 373 / 4096) == floor(s / 11) for s < 593
    localparam int MOD_BASE  = 11;
    localparam int MOD_RECIP = 373;
    localparam int MOD_SHIFT = 12;
    localparam int MOD_PROD_W = 18;
    localparam int MOD_Q_W    = 6;

    // mod 10 by reciprocal for the alternating sum: floor(s * 205 / 2048), s < 128
    localparam int TEN        = 10;
    localparam int DEC_RECIP  = 205;
    localparam int DEC_SHIFT  = 11;
    localparam int DEC_PROD_W = 15;
    localparam int DEC_Q_W    = 4;

    localparam logic [CHK_W-1:0] CHK_MAX = 7'd99;

    typedef logic [DIGIT_W-1:0] t_digit;

    // item moving through the conversion stages
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } t_dab;

    // weighted sums
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [SUM_W-1:0] s1;
        logic [SUM_W-1:0] s2p;
        logic [CHK_W-1:0] low2;
        logic             alt_ok;
    } t_sums;

    // first check digit known
    typedef struct packed {
        logic [NUM_W-1:0] number;
        t_digit           c1;
        logic [SUM_W-1:0] s2;
        logic [CHK_W-1:0] low2;
        logic             alt_ok;
    } t_first;

    // result, packed as it leaves on tdata (check_digits in the lowest bits)
    typedef struct packed {
        logic             legacy_valid;
        logic             id_valid;
        logic [NUM_W-1:0] corrected_number;
        logic [CHK_W-1:0] check_digits;
    } t_result;

    // remainder below 2 gives 0, otherwise 11 minus the remainder
    function automatic t_digit check_digit(input logic [SUM_W-1:0] s);
        logic [MOD_PROD_W-1:0] prod;
        logic [MOD_Q_W-1:0]    q;
        logic [SUM_W-1:0]      r;
        prod = MOD_PROD_W'(s) * MOD_PROD_W'(MOD_RECIP);
        q    = MOD_Q_W'(prod >> MOD_SHIFT);
        r    = s - SUM_W'(q) * SUM_W'(MOD_BASE);
        if (r < SUM_W'(2)) begin
            return '0;
        end
        return DIGIT_W'(SUM_W'(MOD_BASE) - r);
    endfunction

endpackage

// ===== hdl/cdv_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_dabble_stage
// one registered stage of the binary to decimal conversion, eight bits
// ----------------------------------------------------------------------------
module cdv_dabble_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cdv_pkg::t_dab i_data,
    input  logic          i_next_ready,
    output logic          o_ready,
    output logic          o_valid,
    output cdv_pkg::t_dab o_data
);

    logic          r_valid;
    cdv_pkg::t_dab r_data;
    cdv_pkg::t_dab n_data;

    // shift-add-3 over the next eight binary bits
    always_comb begin
        logic [cdv_pkg::BCD_W-1:0] bcd;
        logic [cdv_pkg::BIN_W-1:0] bin;
        bcd = i_data.bcd;
        bin = i_data.bin;
        for (int step = 0; step < cdv_pkg::STEP_BITS; step++) begin
            for (int k = 0; k < cdv_pkg::DIGITS; k++) begin
                if (bcd[k*cdv_pkg::DIGIT_W +: cdv_pkg::DIGIT_W] >= 4'd5) begin
                    bcd[k*cdv_pkg::DIGIT_W +: cdv_pkg::DIGIT_W] =
                        bcd[k*cdv_pkg::DIGIT_W +: cdv_pkg::DIGIT_W] + 4'd3;
                end
            end
            bcd = {bcd[cdv_pkg::BCD_W-2:0], bin[cdv_pkg::BIN_W-1]};
            bin = {bin[cdv_pkg::BIN_W-2:0], 1'b0};
        end
        n_data.number = i_data.number;
        n_data.bin    = bin;
        n_data.bcd    = bcd;
    end

    assign o_ready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/cdv_sum_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_sum_stage
// weighted digit sums for both check digits and the alternating root sum
// ----------------------------------------------------------------------------
module cdv_sum_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cdv_pkg::t_dab  i_data,
    input  logic           i_next_ready,
    output logic           o_ready,
    output logic           o_valid,
    output cdv_pkg::t_sums o_data
);

    logic           r_valid;
    cdv_pkg::t_sums r_data;
    cdv_pkg::t_sums n_data;

    always_comb begin
        logic [cdv_pkg::SUM_W-1:0]      s1;
        logic [cdv_pkg::SUM_W-1:0]      s2p;
        logic [cdv_pkg::ALT_W-1:0]      alt;
        logic [cdv_pkg::DIGIT_W:0]      dbl;
        cdv_pkg::t_digit                d;
        cdv_pkg::t_digit                d0;
        cdv_pkg::t_digit                d1;
        logic [cdv_pkg::DEC_PROD_W-1:0] prod;
        logic [cdv_pkg::DEC_Q_W-1:0]    q;
        s1  = '0;
        s2p = '0;
        alt = '0;
        // root and branch digits, most significant first
        for (int i = 0; i < cdv_pkg::SUM_DIGITS; i++) begin
            d   = i_data.bcd[(cdv_pkg::LEAD_POS - i)*cdv_pkg::DIGIT_W +: cdv_pkg::DIGIT_W];
            s1  = s1 + cdv_pkg::SUM_W'(d) * cdv_pkg::SUM_W'(cdv_pkg::W_FIRST[i]);
            s2p = s2p + cdv_pkg::SUM_W'(d) * cdv_pkg::SUM_W'(cdv_pkg::W_SECOND[i]);
        end
        // low eight root digits, lowest root digit weight 1, then 2, 1, ...
        for (int j = 0; j < cdv_pkg::ROOT_DIGITS; j++) begin
            d = i_data.bcd[(cdv_pkg::ROOT_POS + j)*cdv_pkg::DIGIT_W +: cdv_pkg::DIGIT_W];
            if (j % 2 == 1) begin
                dbl = {d, 1'b0};
                if (dbl > 5'd9) begin
                    dbl = dbl - 5'd9;
                end
            end else begin
                dbl = {1'b0, d};
            end
            alt = alt + cdv_pkg::ALT_W'(dbl);
        end
        prod = cdv_pkg::DEC_PROD_W'(alt) * cdv_pkg::DEC_PROD_W'(cdv_pkg::DEC_RECIP);
        q    = cdv_pkg::DEC_Q_W'(prod >> cdv_pkg::DEC_SHIFT);
        d0   = i_data.bcd[0 +: cdv_pkg::DIGIT_W];
        d1   = i_data.bcd[cdv_pkg::DIGIT_W +: cdv_pkg::DIGIT_W];
        n_data.number = i_data.number;
        n_data.s1     = s1;
        n_data.s2p    = s2p;
        n_data.low2   = cdv_pkg::CHK_W'(d1) * cdv_pkg::CHK_W'(cdv_pkg::TEN)
                      + cdv_pkg::CHK_W'(d0);
        n_data.alt_ok = (alt == cdv_pkg::ALT_W'(q) * cdv_pkg::ALT_W'(cdv_pkg::TEN));
    end

    assign o_ready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/cdv_first_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_first_stage
// first check digit and the completed second weighted sum
// ----------------------------------------------------------------------------
module cdv_first_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cdv_pkg::t_sums  i_data,
    input  logic            i_next_ready,
    output logic            o_ready,
    output logic            o_valid,
    output cdv_pkg::t_first o_data
);

    logic            r_valid;
    cdv_pkg::t_first r_data;
    cdv_pkg::t_first n_data;

    always_comb begin
        cdv_pkg::t_digit c1;
        c1 = cdv_pkg::check_digit(i_data.s1);
        n_data.number = i_data.number;
        n_data.c1     = c1;
        n_data.s2     = i_data.s2p
                      + cdv_pkg::SUM_W'(c1) * cdv_pkg::SUM_W'(cdv_pkg::W_SECOND_LAST);
        n_data.low2   = i_data.low2;
        n_data.alt_ok = i_data.alt_ok;
    end

    assign o_ready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/cdv_out_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_out_stage
// second check digit, corrected number, flags and the result register
// ----------------------------------------------------------------------------
module cdv_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cdv_pkg::t_first  i_data,
    input  logic             i_next_ready,
    output logic             o_ready,
    output logic             o_valid,
    output cdv_pkg::t_result o_data
);

    logic             r_valid;
    cdv_pkg::t_result r_data;
    cdv_pkg::t_result n_data;

    always_comb begin
        cdv_pkg::t_digit           c2;
        logic [cdv_pkg::CHK_W-1:0] checks;
        logic                      ok;
        c2     = cdv_pkg::check_digit(i_data.s2);
        checks = cdv_pkg::CHK_W'(i_data.c1) * cdv_pkg::CHK_W'(cdv_pkg::TEN)
               + cdv_pkg::CHK_W'(c2);
        // input equals its corrected form exactly when the given digits match
        ok     = (checks == i_data.low2);
        n_data.check_digits     = checks;
        n_data.corrected_number = i_data.number - cdv_pkg::NUM_W'(i_data.low2)
                                + cdv_pkg::NUM_W'(checks);
        n_data.id_valid         = ok;
        n_data.legacy_valid     = ok && i_data.alt_ok;
    end

    assign o_ready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/cnpj_check_digit_validator_top.sv =====
// ----------------------------------------------------------------------------
// cnpj_check_digit_validator_top
// mod-11 check digit validator for 14-digit registry numbers
// ----------------------------------------------------------------------------
// Takes one 14-digit registry number per transaction as a binary value and
// returns its two mod-11 check digits, the number with those digits put in
// place, a valid flag and an older-format flag. The block holds no state
// between items. A new transaction is taken every clock cycle while the output
// side is not stalled; each result passes through the input register, the
// binary to decimal conversion (six stages of eight shift-add-3 steps), and
// then the weighted sum, first check digit and result registers before it is
// presented on the master side. Every stage has its own valid bit, so empty
// stages fill while a finished result waits on the output.
// ----------------------------------------------------------------------------
module cnpj_check_digit_validator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [46:0] number, [47] zero fill
    input  logic [cdv_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // master side
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [6:0] check_digits, [53:7] corrected_number, [54] id_valid,
    // [55] legacy_valid
    output logic [cdv_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    // input register
    logic                      r_in_valid;
    logic [cdv_pkg::NUM_W-1:0] r_in_number;
    logic                      in_ready;

    // conversion chain, index g feeds stage g
    cdv_pkg::t_dab dab_data [0:cdv_pkg::DAB_STAGES];
    logic          dab_vld  [0:cdv_pkg::DAB_STAGES];
    logic          dab_rdy  [0:cdv_pkg::DAB_STAGES];

    cdv_pkg::t_sums   sum_data;
    logic             sum_vld;
    cdv_pkg::t_first  first_data;
    logic             first_vld;
    logic             first_rdy;
    logic             out_rdy;
    cdv_pkg::t_result out_data;

    // input register loads when it is empty or its item moves on
    assign in_ready        = !r_in_valid || dab_rdy[0];
    assign o_s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_number <= i_s_axis_tdata[cdv_pkg::NUM_W-1:0];
        end
    end

    // the leading zero bit pads the number to a whole number of stages
    assign dab_data[0].number = r_in_number;
    assign dab_data[0].bin    = {1'b0, r_in_number};
    assign dab_data[0].bcd    = '0;
    assign dab_vld[0]         = r_in_valid;

    for (genvar g = 0; g < cdv_pkg::DAB_STAGES; g++) begin : g_dab
        cdv_dabble_stage u_dab (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (dab_vld[g]),
            .i_data       (dab_data[g]),
            .i_next_ready (dab_rdy[g+1]),
            .o_ready      (dab_rdy[g]),
            .o_valid      (dab_vld[g+1]),
            .o_data       (dab_data[g+1])
        );
    end

    // weighted sums over the decimal digits
    cdv_sum_stage u_sum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (dab_vld[cdv_pkg::DAB_STAGES]),
        .i_data       (dab_data[cdv_pkg::DAB_STAGES]),
        .i_next_ready (first_rdy),
        .o_ready      (dab_rdy[cdv_pkg::DAB_STAGES]),
        .o_valid      (sum_vld),
        .o_data       (sum_data)
    );

    // first check digit, folded into the second sum
    cdv_first_stage u_first (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (sum_vld),
        .i_data       (sum_data),
        .i_next_ready (out_rdy),
        .o_ready      (first_rdy),
        .o_valid      (first_vld),
        .o_data       (first_data)
    );

    // second check digit and the result register on the master side
    cdv_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (first_vld),
        .i_data       (first_data),
        .i_next_ready (i_m_axis_tready),
        .o_ready      (out_rdy),
        .o_valid      (o_m_axis_tvalid),
        .o_data       (out_data)
    );

    assign o_m_axis_tdata = out_data;

`ifndef SYNTHESIS
    // older-format flag never stands without the valid flag
    a_legacy_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_data.id_valid || !out_data.legacy_valid))
        else $error("legacy_valid set on an invalid number");

    // two decimal digits never exceed 99
    a_checks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_data.check_digits <= cdv_pkg::CHK_MAX))
        else $error("check digits out of range");

    // the slave side stalls only when every stage is full behind a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output backpressure");

    // a root sum that is not a multiple of ten keeps the older-format flag clear
    a_valid_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (first_vld && out_rdy && (first_data.alt_ok == 1'b0)) |=>
            (!o_m_axis_tvalid || !out_data.legacy_valid))
        else $error("legacy_valid set without a matching root sum");
`endif

endmodule
